// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top level of the light schedule interpolator
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dlsi_pkg.sv -----
// shared types, constants and helpers of the light schedule interpolator
// no dependencies; used by the controller, the datapath and the top level
package dlsi_pkg;

   // default table depth
   localparam int MAX_ENTRIES_DEF = 16;

   // field widths
   localparam int INDEX_W     = 4;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int LEVEL_W     = 7;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int WEEKDAY_W   = 3;
   localparam int TABLE_LEN_W = 5;
   localparam int ENTRY_W     = HOUR_W + MINUTE_W + LEVEL_W;

   // csr port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_AT_DST = 2'd1;

   // item kinds
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TIME = 1'b1;

   // calendar constants
   localparam int HOURS_PER_DAY = 24;
   localparam int DAY_MINUTES   = HOURS_PER_DAY * 60;
   localparam int SWITCH_DAY    = 25;
   localparam int SWITCH_HOUR   = 3;
   localparam int SUNDAY_CODE   = 7;
   localparam int LEVEL_MAX     = 127;

   // datapath widths
   localparam int TOD_W     = 11;             // minute of day, out-of-range entries up to 1923
   localparam int SPAN_W    = 13;             // signed span and elapsed minutes
   localparam int MUL_A_W   = LEVEL_W + 2;    // signed level or level difference
   localparam int NUM_W     = 22;             // signed interpolation numerator
   localparam int DIV_W     = NUM_W - 1;      // magnitude bits of a non-negative numerator
   localparam int REM_W     = SPAN_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_SPAN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_entry;
      logic capture_time;
      logic walk_rd;
      logic eval_en;
      logic eval_first;
      logic eval_final;
      logic resolve;
      logic mul_lo;
      logic mul_hi;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

   // hour * 60 + minute, with 60 = 64 - 4
   function automatic logic [TOD_W-1:0] minute_of_day(input logic [HOUR_W-1:0] h,
                                                     input logic [MINUTE_W-1:0] m);
      logic [TOD_W-1:0] hx;
      hx = TOD_W'(h);
      return (hx << 6) - (hx << 2) + TOD_W'(m);
   endfunction

endpackage

// ----- rtl/core/dst_light_schedule_interpolator.sv -----
// Light schedule interpolator. A load word (cmd 0) writes one schedule point
// into the table and is taken without holding the input, with no result. A time word
// (cmd 1) updates the sticky European summer-time flag, corrects the clock
// hour by one hour modulo 24, walks the first table_length entries (zero taken
// as one, clipped to the table depth) one RAM read per cycle to find the points
// around now (wrapping across midnight), and interpolates the level with one
// shared multiplier and a bit-serial divider that yields one quotient bit per
// cycle. A time word holds the input from the table walk through the span,
// multiply and 21 divider steps until the result is loaded, also while the
// previous result still waits in the output register; the result then sits in
// that register, so the next word is taken while it waits. Writes to the csr
// port are taken at any time but belong to idle periods. Uses dlsi_pkg,
// dlsi_ctrl, dlsi_datapath, assert_macros.svh.
`include "assert_macros.svh"

module dst_light_schedule_interpolator #(
   parameter int MAX_ENTRIES = dlsi_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [dlsi_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [dlsi_pkg::HOUR_W-1:0]         req_entry_hour,
   input  logic [dlsi_pkg::MINUTE_W-1:0]       req_entry_minute,
   input  logic [dlsi_pkg::LEVEL_W-1:0]        req_entry_level,
   input  logic [dlsi_pkg::MONTH_W-1:0]        req_month,
   input  logic [dlsi_pkg::DAY_W-1:0]          req_day,
   input  logic [dlsi_pkg::WEEKDAY_W-1:0]      req_weekday,
   input  logic [dlsi_pkg::HOUR_W-1:0]         req_hour,
   input  logic [dlsi_pkg::MINUTE_W-1:0]       req_minute,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dlsi_pkg::LEVEL_W-1:0]        rsp_brightness,
   output logic                                rsp_status_led_on,
   output logic                                rsp_power_led_on,
   output logic                                rsp_summer_time,
   output logic [dlsi_pkg::HOUR_W-1:0]         rsp_local_hour,
   // csr writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dlsi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dlsi_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LEN_W = $clog2(MAX_ENTRIES + 1);

   dlsi_pkg::cmd_type    cmd;
   dlsi_pkg::status_type status;
   logic [AW-1:0]        walk_addr;
   logic [LEN_W-1:0]     len;

   // csr writes are always taken
   assign csr_ready = 1'b1;

   dlsi_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .len       (len),
      .status    (status),
      .cmd       (cmd),
      .walk_addr (walk_addr)
   );

   dlsi_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .walk_addr         (walk_addr),
      .status            (status),
      .len               (len),
      .req_entry_index   (req_entry_index),
      .req_entry_hour    (req_entry_hour),
      .req_entry_minute  (req_entry_minute),
      .req_entry_level   (req_entry_level),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_weekday       (req_weekday),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_brightness    (rsp_brightness),
      .rsp_status_led_on (rsp_status_led_on),
      .rsp_power_led_on  (rsp_power_led_on),
      .rsp_summer_time   (rsp_summer_time),
      .rsp_local_hour    (rsp_local_hour)
   );

   // result and handshake checks
   `ASSERT_ALWAYS(a_led_exclusive, clock, reset, !rsp_valid || (rsp_status_led_on != rsp_power_led_on), "status and power leds both on or both off")
   `ASSERT_IMPLY(a_led_level, clock, reset, rsp_valid, rsp_status_led_on == (rsp_brightness != '0), "status led disagrees with brightness")
   `ASSERT_IMPLY(a_hour_wrap, clock, reset, rsp_valid, rsp_local_hour < dlsi_pkg::HOUR_W'(dlsi_pkg::HOURS_PER_DAY), "local hour not wrapped")
   `ASSERT_NEXT(a_time_busy, clock, reset, req_valid && !req_stall && (req_cmd == dlsi_pkg::CMD_TIME), req_stall, "time word accepted but input not held")
   `ASSERT_NEXT(a_load_single, clock, reset, req_valid && !req_stall && (req_cmd == dlsi_pkg::CMD_LOAD), !req_stall, "load word held the input")

endmodule

// ----- rtl/core/dlsi_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dlsi_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dlsi_datapath.sv -----
// datapath: csr registers, schedule table, summer-time logic, span search,
// interpolation multiply and bit-serial divider; uses dlsi_pkg and dlsi_ram
module dlsi_datapath #(
   parameter int MAX_ENTRIES = dlsi_pkg::MAX_ENTRIES_DEF,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int LEN_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dlsi_pkg::cmd_type                   cmd,
   input  logic [AW-1:0]                       walk_addr,
   output dlsi_pkg::status_type                status,
   output logic [LEN_W-1:0]                    len,
   // input item fields
   input  logic [dlsi_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [dlsi_pkg::HOUR_W-1:0]         req_entry_hour,
   input  logic [dlsi_pkg::MINUTE_W-1:0]       req_entry_minute,
   input  logic [dlsi_pkg::LEVEL_W-1:0]        req_entry_level,
   input  logic [dlsi_pkg::MONTH_W-1:0]        req_month,
   input  logic [dlsi_pkg::DAY_W-1:0]          req_day,
   input  logic [dlsi_pkg::WEEKDAY_W-1:0]      req_weekday,
   input  logic [dlsi_pkg::HOUR_W-1:0]         req_hour,
   input  logic [dlsi_pkg::MINUTE_W-1:0]       req_minute,
   // csr writes
   input  logic                                csr_we,
   input  logic [dlsi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dlsi_pkg::CSR_DATA_W-1:0]     csr_data,
   // result word
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dlsi_pkg::LEVEL_W-1:0]        rsp_brightness,
   output logic                                rsp_status_led_on,
   output logic                                rsp_power_led_on,
   output logic                                rsp_summer_time,
   output logic [dlsi_pkg::HOUR_W-1:0]         rsp_local_hour
);

   localparam int TOD_W   = dlsi_pkg::TOD_W;
   localparam int SPAN_W  = dlsi_pkg::SPAN_W;
   localparam int MUL_A_W = dlsi_pkg::MUL_A_W;
   localparam int NUM_W   = dlsi_pkg::NUM_W;
   localparam int DIV_W   = dlsi_pkg::DIV_W;
   localparam int REM_W   = dlsi_pkg::REM_W;
   localparam int LEVEL_W = dlsi_pkg::LEVEL_W;
   localparam int HOUR_W  = dlsi_pkg::HOUR_W;

   // csr registers
   logic [dlsi_pkg::TABLE_LEN_W-1:0] table_length_ff;
   logic                             clock_at_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= dlsi_pkg::TABLE_LEN_W'(1);
         clock_at_dst_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            dlsi_pkg::CSR_TABLE_LENGTH: table_length_ff <= csr_data;
            dlsi_pkg::CSR_CLOCK_AT_DST: clock_at_dst_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // entries in use, zero taken as one, clipped to the table depth
   always_comb begin
      if (table_length_ff == '0) begin
         len = LEN_W'(1);
      end else if (int'(table_length_ff) > MAX_ENTRIES) begin
         len = LEN_W'(MAX_ENTRIES);
      end else begin
         len = LEN_W'(table_length_ff);
      end
   end

   // schedule table
   logic                            tbl_we;
   logic [dlsi_pkg::ENTRY_W-1:0]    tbl_rd_data;

   assign tbl_we = cmd.load_entry && (int'(req_entry_index) < MAX_ENTRIES);

   dlsi_ram #(
      .WIDTH (dlsi_pkg::ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_entry_hour, req_entry_minute, req_entry_level}),
      .rd_en   (cmd.walk_rd),
      .rd_addr (walk_addr),
      .rd_data (tbl_rd_data)
   );

   // summer-time rule and hour correction
   logic                   dst_ff;
   logic                   dst_in;
   logic [HOUR_W-1:0]      lhour_ff;
   logic [HOUR_W-1:0]      lhour_in;
   logic [TOD_W-1:0]       now_ff;
   logic [dlsi_pkg::WEEKDAY_W-1:0] wday;
   logic                   late_week;
   logic                   after_switch;
   logic [5:0]             hour_sum;

   always_comb begin
      wday = (int'(req_weekday) == dlsi_pkg::SUNDAY_CODE) ? '0 : req_weekday;
      // last week of the month: day - weekday >= 25
      late_week = {1'b0, req_day} >= (6'(dlsi_pkg::SWITCH_DAY) + 6'(wday));
      after_switch = req_hour >= HOUR_W'(dlsi_pkg::SWITCH_HOUR);

      case (req_month) inside
         [4'd0:4'd2], [4'd11:4'd15]: dst_in = 1'b0;
         [4'd4:4'd9]:                dst_in = 1'b1;
         4'd3:                       dst_in = (late_week && after_switch) ? 1'b1 : dst_ff;
         4'd10:                      dst_in = !late_week || !after_switch;
         default:                    dst_in = dst_ff;
      endcase

      // shift one hour against the clock's own setting, then wrap
      if (dst_in && !clock_at_dst_ff) begin
         hour_sum = 6'(req_hour) + 6'd1;
      end else if (!dst_in && clock_at_dst_ff) begin
         hour_sum = 6'(req_hour) + 6'(dlsi_pkg::HOURS_PER_DAY - 1);
      end else begin
         hour_sum = 6'(req_hour);
      end
      if (hour_sum >= 6'(2 * dlsi_pkg::HOURS_PER_DAY)) begin
         lhour_in = HOUR_W'(hour_sum - 6'(2 * dlsi_pkg::HOURS_PER_DAY));
      end else if (hour_sum >= 6'(dlsi_pkg::HOURS_PER_DAY)) begin
         lhour_in = HOUR_W'(hour_sum - 6'(dlsi_pkg::HOURS_PER_DAY));
      end else begin
         lhour_in = HOUR_W'(hour_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_ff <= 1'b0;
      end else if (cmd.capture_time) begin
         dst_ff <= dst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_time) begin
         lhour_ff <= lhour_in;
         now_ff   <= dlsi_pkg::minute_of_day(lhour_in, req_minute);
      end
   end

   // table walk: last entry at or before now, first entry after now
   logic [TOD_W-1:0]   ent_t;
   logic [LEVEL_W-1:0] ent_l;
   logic               have_last_ff;
   logic               have_next_ff;
   logic [TOD_W-1:0]   last_t_ff, next_t_ff, first_t_ff, fin_t_ff;
   logic [LEVEL_W-1:0] last_l_ff, next_l_ff, first_l_ff, fin_l_ff;

   assign ent_t = dlsi_pkg::minute_of_day(
      tbl_rd_data[dlsi_pkg::ENTRY_W-1 -: HOUR_W],
      tbl_rd_data[LEVEL_W +: dlsi_pkg::MINUTE_W]);
   assign ent_l = tbl_rd_data[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.capture_time) begin
         have_last_ff <= 1'b0;
         have_next_ff <= 1'b0;
      end else if (cmd.eval_en) begin
         if (now_ff >= ent_t) begin
            have_last_ff <= 1'b1;
         end
         if (now_ff < ent_t) begin
            have_next_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_en) begin
         if (now_ff >= ent_t) begin
            last_t_ff <= ent_t;
            last_l_ff <= ent_l;
         end
         if (!have_next_ff && (now_ff < ent_t)) begin
            next_t_ff <= ent_t;
            next_l_ff <= ent_l;
         end
         if (cmd.eval_first) begin
            first_t_ff <= ent_t;
            first_l_ff <= ent_l;
         end
         if (cmd.eval_final) begin
            fin_t_ff <= ent_t;
            fin_l_ff <= ent_l;
         end
      end
   end

   // span and elapsed minutes, wrapping across midnight
   logic [TOD_W-1:0]         lo_t, hi_t;
   logic [LEVEL_W-1:0]       lo_l, hi_l;
   logic signed [SPAN_W-1:0] lo_s, hi_s, now_s, day_s;
   logic signed [SPAN_W-1:0] span_in, elapsed_in;
   logic signed [SPAN_W-1:0] d_ff, n_ff;
   logic [LEVEL_W-1:0]       lvl_lo_ff, lvl_hi_ff;

   always_comb begin
      lo_t  = have_last_ff ? last_t_ff : fin_t_ff;
      lo_l  = have_last_ff ? last_l_ff : fin_l_ff;
      hi_t  = have_next_ff ? next_t_ff : first_t_ff;
      hi_l  = have_next_ff ? next_l_ff : first_l_ff;
      lo_s  = $signed(SPAN_W'(lo_t));
      hi_s  = $signed(SPAN_W'(hi_t));
      now_s = $signed(SPAN_W'(now_ff));
      day_s = $signed(SPAN_W'(dlsi_pkg::DAY_MINUTES));
      if (hi_t >= lo_t) begin
         span_in    = hi_s - lo_s;
         elapsed_in = now_s - lo_s;
      end else begin
         span_in    = hi_s + day_s - lo_s;
         elapsed_in = (now_ff >= lo_t) ? (now_s - lo_s) : (now_s + day_s - lo_s);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         d_ff      <= span_in;
         n_ff      <= elapsed_in;
         lvl_lo_ff <= lo_l;
         lvl_hi_ff <= hi_l;
      end
   end

   // numerator lo*d + (hi - lo)*n on one shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [SPAN_W-1:0]  mul_b;
   logic signed [NUM_W-1:0]   mul_p;
   logic signed [NUM_W-1:0]   num_ff;

   always_comb begin
      if (cmd.mul_hi) begin
         mul_a = $signed(MUL_A_W'(lvl_hi_ff)) - $signed(MUL_A_W'(lvl_lo_ff));
         mul_b = n_ff;
      end else begin
         mul_a = $signed(MUL_A_W'(lvl_lo_ff));
         mul_b = d_ff;
      end
   end

   assign mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_lo) begin
         num_ff <= mul_p;
      end else if (cmd.mul_hi) begin
         num_ff <= num_ff + mul_p;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DIV_W-1:0] quo_ff;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] divisor;
   logic             fits;

   assign rem_sh  = {rem_ff[REM_W-2:0], quo_ff[DIV_W-1]};
   assign divisor = REM_W'($unsigned(d_ff));
   assign fits    = rem_sh >= divisor;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         // a negative numerator floors below zero and clamps to zero
         quo_ff <= num_ff[NUM_W-1] ? '0 : num_ff[DIV_W-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? (rem_sh - divisor) : rem_sh;
      end
   end

   // result word
   logic [LEVEL_W-1:0] level;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] brightness_ff;
   logic               summer_ff;
   logic [HOUR_W-1:0]  local_hour_ff;

   always_comb begin
      if (d_ff[SPAN_W-1] || (d_ff == '0)) begin
         // no span: hold the earlier point's level
         level = lvl_lo_ff;
      end else if (quo_ff > DIV_W'(dlsi_pkg::LEVEL_MAX)) begin
         level = LEVEL_W'(dlsi_pkg::LEVEL_MAX);
      end else begin
         level = quo_ff[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         brightness_ff <= level;
         summer_ff     <= dst_ff;
         local_hour_ff <= lhour_ff;
      end
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_brightness     = brightness_ff;
   assign rsp_status_led_on  = brightness_ff != '0;
   assign rsp_power_led_on   = brightness_ff == '0;
   assign rsp_summer_time    = summer_ff;
   assign rsp_local_hour     = local_hour_ff;

endmodule

// ----- rtl/core/dlsi_ctrl.sv -----
// controller: state machine that sequences load, table walk, multiply,
// division and result hand-off; uses dlsi_pkg
module dlsi_ctrl #(
   parameter int MAX_ENTRIES = dlsi_pkg::MAX_ENTRIES_DEF,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int LEN_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_cmd,
   output logic                 req_stall,
   input  logic [LEN_W-1:0]     len,
   input  dlsi_pkg::status_type status,
   output dlsi_pkg::cmd_type    cmd,
   output logic [AW-1:0]        walk_addr
);

   localparam int DIV_CNT_W = dlsi_pkg::DIV_CNT_W;

   dlsi_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        walk_idx_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 eval_en_ff, eval_first_ff, eval_final_ff;
   logic                 walk_last;
   logic                 div_last;
   logic                 take_time;

   assign walk_last = (LEN_W'(walk_idx_ff) + LEN_W'(1)) == len;
   assign div_last  = div_cnt_ff == DIV_CNT_W'(dlsi_pkg::DIV_W - 1);
   assign take_time = req_valid && (req_cmd == dlsi_pkg::CMD_TIME);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlsi_pkg::ST_IDLE:     if (take_time) state_in = dlsi_pkg::ST_WALK;
         dlsi_pkg::ST_WALK:     if (walk_last) state_in = dlsi_pkg::ST_FLUSH;
         dlsi_pkg::ST_FLUSH:    state_in = dlsi_pkg::ST_SPAN;
         dlsi_pkg::ST_SPAN:     state_in = dlsi_pkg::ST_MUL_LO;
         dlsi_pkg::ST_MUL_LO:   state_in = dlsi_pkg::ST_MUL_HI;
         dlsi_pkg::ST_MUL_HI:   state_in = dlsi_pkg::ST_DIV_LOAD;
         dlsi_pkg::ST_DIV_LOAD: state_in = dlsi_pkg::ST_DIV;
         dlsi_pkg::ST_DIV:      if (div_last) state_in = dlsi_pkg::ST_SEND;
         dlsi_pkg::ST_SEND:     if (status.out_free) state_in = dlsi_pkg::ST_IDLE;
         default:               state_in = dlsi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlsi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // walk and divider counters
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_idx_ff <= '0;
         div_cnt_ff  <= '0;
      end else begin
         if (state_ff == dlsi_pkg::ST_IDLE) begin
            walk_idx_ff <= '0;
         end else if (state_ff == dlsi_pkg::ST_WALK) begin
            walk_idx_ff <= walk_idx_ff + AW'(1);
         end
         if (state_ff == dlsi_pkg::ST_DIV_LOAD) begin
            div_cnt_ff <= '0;
         end else if (state_ff == dlsi_pkg::ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   // table read data arrives in the cycle after the address
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_en_ff    <= 1'b0;
         eval_first_ff <= 1'b0;
         eval_final_ff <= 1'b0;
      end else begin
         eval_en_ff    <= state_ff == dlsi_pkg::ST_WALK;
         eval_first_ff <= (state_ff == dlsi_pkg::ST_WALK) && (walk_idx_ff == '0);
         eval_final_ff <= (state_ff == dlsi_pkg::ST_WALK) && walk_last;
      end
   end

   // outputs
   always_comb begin
      req_stall        = state_ff != dlsi_pkg::ST_IDLE;
      cmd              = '0;
      cmd.load_entry   = (state_ff == dlsi_pkg::ST_IDLE) && req_valid &&
                         (req_cmd == dlsi_pkg::CMD_LOAD);
      cmd.capture_time = (state_ff == dlsi_pkg::ST_IDLE) && take_time;
      cmd.walk_rd      = state_ff == dlsi_pkg::ST_WALK;
      cmd.eval_en      = eval_en_ff;
      cmd.eval_first   = eval_first_ff;
      cmd.eval_final   = eval_final_ff;
      cmd.resolve      = state_ff == dlsi_pkg::ST_SPAN;
      cmd.mul_lo       = state_ff == dlsi_pkg::ST_MUL_LO;
      cmd.mul_hi       = state_ff == dlsi_pkg::ST_MUL_HI;
      cmd.div_load     = state_ff == dlsi_pkg::ST_DIV_LOAD;
      cmd.div_step     = state_ff == dlsi_pkg::ST_DIV;
      cmd.out_load     = (state_ff == dlsi_pkg::ST_SEND) && status.out_free;
   end

   assign walk_addr = walk_idx_ff;

endmodule
